/* rtl/kms_pkg.sv */
// ----------------------------------------------------------------------------
// kms_pkg
// Shared constants, the scan record type and a helper for the key matrix
// scanner.
// ----------------------------------------------------------------------------
package kms_pkg;

    localparam int ROWS        = 5;
    localparam int COLS        = 8;
    localparam int ROW_W       = 3;
    localparam int COL_W       = 3;
    localparam int KEY_W       = 6;
    localparam int DRIVE_W     = 5;
    localparam int LEVEL_W     = 8;
    localparam int INTERVAL_W  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd2;
    localparam logic [INTERVAL_W-1:0] TICKS_MAX      = 8'd255;

    // one scanned row, handed from the front to the back
    typedef struct packed {
        logic [LEVEL_W-1:0] change_mask;
        logic [LEVEL_W-1:0] levels;
        logic [ROW_W-1:0]   row;
        logic [DRIVE_W-1:0] drive;
    } t_scan;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    // index of the lowest set bit, zero for an empty mask
    function automatic logic [COL_W-1:0] lowest_set(input logic [LEVEL_W-1:0] mask);
        logic [COL_W-1:0] idx;
        idx = '0;
        for (int i = LEVEL_W - 1; i >= 0; i--) begin
            if (mask[i]) begin
                idx = COL_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/kms_front.sv */
// ----------------------------------------------------------------------------
// kms_front
// Counts ticks, scans the driven row on the configured interval, updates
// the stored key levels and queues one record per scan.
// ----------------------------------------------------------------------------
module kms_front import kms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [INTERVAL_W-1:0] i_cfg_data,
    input  logic                  i_accept,
    input  logic [LEVEL_W-1:0]    i_column_levels,
    output logic                  o_scan_push,
    output t_scan                 o_scan
);

    logic [INTERVAL_W-1:0] r_interval;
    logic [INTERVAL_W-1:0] r_ticks;
    logic [INTERVAL_W-1:0] n_ticks;
    logic [ROW_W-1:0]      r_row;
    logic [ROW_W-1:0]      n_row;
    logic [LEVEL_W-1:0]    r_levels [ROWS];
    logic                  scan_hit;

    // tick count with saturation, scan when interval is reached
    always_comb begin
        n_ticks  = (r_ticks < TICKS_MAX) ? r_ticks + 1'b1 : TICKS_MAX;
        scan_hit = (n_ticks >= r_interval);
        n_row    = (r_row == ROW_W'(ROWS - 1)) ? '0 : r_row + 1'b1;
    end

    // record for the back end
    always_comb begin
        o_scan_push        = i_accept && scan_hit;
        o_scan.change_mask = i_column_levels ^ r_levels[r_row];
        o_scan.levels      = i_column_levels;
        o_scan.row         = r_row;
        o_scan.drive       = DRIVE_W'(1) << n_row;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
            r_ticks    <= '0;
            r_row      <= '0;
            for (int r = 0; r < ROWS; r++) begin
                r_levels[r] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_interval <= i_cfg_data;
            end
            if (i_accept) begin
                if (scan_hit) begin
                    r_ticks         <= '0;
                    r_row           <= n_row;
                    r_levels[r_row] <= i_column_levels;
                end else begin
                    r_ticks <= n_ticks;
                end
            end
        end
    end

endmodule

/* rtl/kms_fifo.sv */
// ----------------------------------------------------------------------------
// kms_fifo
// Short queue of scan records between the front and the back.
// ----------------------------------------------------------------------------
module kms_fifo import kms_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  t_scan  i_wr_data,
    input  logic   i_rd,
    output t_scan  o_rd_data,
    output t_qstat o_stat
);

    t_scan             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              wr_ok;
    logic              rd_ok;

    // status and guarded strobes
    always_comb begin
        o_stat.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
        o_stat.empty = (r_count == '0);
        wr_ok        = i_wr && !o_stat.full;
        rd_ok        = i_rd && !o_stat.empty;
        o_rd_data    = r_mem[r_rd_ptr];
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr_ok) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (rd_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_count <= r_count + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/kms_back.sv */
// ----------------------------------------------------------------------------
// kms_back
// Takes scan records; while holding one with the output free, emits one result
// per cycle: one event per changed column in column order, or a single no-change result.
// ----------------------------------------------------------------------------
module kms_back import kms_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_scan              i_scan,
    input  t_qstat             i_qstat,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic               o_change_valid,
    output logic [KEY_W-1:0]   o_key_index,
    output logic               o_key_level,
    output logic [DRIVE_W-1:0] o_row_drive,
    output logic               o_last_of_scan
);

    logic               r_busy;
    t_scan              r_rec;
    logic               r_out_valid;
    logic               r_change_valid;
    logic [KEY_W-1:0]   r_key_index;
    logic               r_key_level;
    logic [DRIVE_W-1:0] r_row_drive;
    logic               r_last;
    logic               out_free;
    logic               emit;
    logic [COL_W-1:0]   col;
    logic [LEVEL_W-1:0] n_mask;
    logic               no_change;

    // next event from the held record
    always_comb begin
        out_free  = !r_out_valid || i_pop;
        emit      = r_busy && out_free;
        o_q_pop   = !r_busy && !i_qstat.empty;
        no_change = (r_rec.change_mask == '0);
        col       = lowest_set(r_rec.change_mask);
        n_mask    = r_rec.change_mask & (r_rec.change_mask - 1'b1);
    end

    // record holder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
        end else if (emit) begin
            r_busy <= !(no_change || n_mask == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_scan;
        end else if (emit) begin
            r_rec.change_mask <= n_mask;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_pop) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_row_drive <= r_rec.drive;
            if (no_change) begin
                r_change_valid <= 1'b0;
                r_key_index    <= '0;
                r_key_level    <= 1'b0;
                r_last         <= 1'b1;
            end else begin
                r_change_valid <= 1'b1;
                r_key_index    <= KEY_W'(r_rec.row) * KEY_W'(COLS) + KEY_W'(col);
                r_key_level    <= r_rec.levels[col];
                r_last         <= (n_mask == '0);
            end
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_change_valid = r_change_valid;
    assign o_key_index    = r_key_index;
    assign o_key_level    = r_key_level;
    assign o_row_drive    = r_row_drive;
    assign o_last_of_scan = r_last;

endmodule

/* rtl/key_matrix_scanner.sv */
// ----------------------------------------------------------------------------
// key_matrix_scanner
// Row-by-row key matrix scanner reporting key level changes as events.
//
//   channel   direction  handshake           transfer when
//   ticks     in         i_push / o_full     i_push && !o_full
//   results   out        o_empty / i_pop     i_pop && !o_empty
//   config    in         i_cfg_valid/ready   i_cfg_valid && o_cfg_ready
//
// a tick is accepted whenever o_full is low; a scan with n changed keys gives max(n,1)
// results, one per cycle while the back end holds the record and its output is free
// the four-entry scan queue lets ticks keep coming while results wait
// o_full rises only when that queue is full; a stalled pop holds the result
// reset clears key levels, tick count and row, interval returns to 2
// ----------------------------------------------------------------------------
module key_matrix_scanner import kms_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    output logic                  o_full,
    input  logic [LEVEL_W-1:0]    i_column_levels,
    output logic                  o_empty,
    input  logic                  i_pop,
    output logic                  o_change_valid,
    output logic [KEY_W-1:0]      o_key_index,
    output logic                  o_key_level,
    output logic [DRIVE_W-1:0]    o_row_drive,
    output logic                  o_last_of_scan,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [INTERVAL_W-1:0] i_cfg_data
);

    t_scan  scan_wr;
    t_scan  scan_rd;
    t_qstat qstat;
    logic   scan_push;
    logic   q_pop;
    logic   accept;

    // tick transfer
    assign accept      = i_push && !o_full;
    assign o_full      = qstat.full;
    assign o_cfg_ready = 1'b1;

    kms_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_data      (i_cfg_data),
        .i_accept        (accept),
        .i_column_levels (i_column_levels),
        .o_scan_push     (scan_push),
        .o_scan          (scan_wr)
    );

    kms_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (scan_push),
        .i_wr_data (scan_wr),
        .i_rd      (q_pop),
        .o_rd_data (scan_rd),
        .o_stat    (qstat)
    );

    kms_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_scan         (scan_rd),
        .i_qstat        (qstat),
        .o_q_pop        (q_pop),
        .i_pop          (i_pop),
        .o_empty        (o_empty),
        .o_change_valid (o_change_valid),
        .o_key_index    (o_key_index),
        .o_key_level    (o_key_level),
        .o_row_drive    (o_row_drive),
        .o_last_of_scan (o_last_of_scan)
    );

    // a no-change result is a bare, final one
    a_nochange_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_change_valid) |-> (o_key_index == '0 && !o_key_level && o_last_of_scan))
        else $error("no-change result carries event data");

    // every result names exactly one driven row
    a_drive_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> $onehot(o_row_drive))
        else $error("row drive not one-hot");

    // only events can be followed by more results of the same scan
    a_nonlast_is_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_last_of_scan) |-> o_change_valid)
        else $error("non-final result without a change");

endmodule
